FILE: rtl/dual_header_uart_deframer_macros.svh
// ----------------------------------------------------------------------------
// Dual header UART deframer assertion macros
// Shorthand for clocked checks, sampled on clock and quiet while in reset.
// ----------------------------------------------------------------------------
`ifndef DUAL_HEADER_UART_DEFRAMER_MACROS_SVH
`define DUAL_HEADER_UART_DEFRAMER_MACROS_SVH

// Same-cycle implication
`define DHUD_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define DHUD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/dhud_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dual header UART deframer package
// Shared beat types, request and result codes, register indexes and defaults.
// ----------------------------------------------------------------------------
package dhud_pkg;

   // Default sizing
   localparam int MAX_PAYLOAD_DEF = 32;
   localparam int RING_SLOTS_DEF  = 4;

   // Register reset values
   localparam logic [7:0] CMD_HEAD_RST = 8'd170;
   localparam logic [7:0] TUN_HEAD_RST = 8'd165;
   localparam logic [7:0] SET_CODE_RST = 8'd1;
   localparam logic [7:0] LOST_MAX     = 8'd255;

   // Register indexes
   localparam logic [1:0] CSR_CMD_HEAD = 2'd0;
   localparam logic [1:0] CSR_TUN_HEAD = 2'd1;
   localparam logic [1:0] CSR_SET_CODE = 2'd2;

   // Request codes
   localparam logic [1:0] REQ_BYTE    = 2'd0;
   localparam logic [1:0] REQ_OVERRUN = 2'd1;
   localparam logic [1:0] REQ_READ    = 2'd2;
   localparam logic [1:0] REQ_POP     = 2'd3;

   // Result kinds
   localparam logic [1:0] KIND_STATUS  = 2'd0;
   localparam logic [1:0] KIND_COMMAND = 2'd1;
   localparam logic [1:0] KIND_PAYLOAD = 2'd2;
   localparam logic [1:0] KIND_EMPTY   = 2'd3;

   typedef struct packed {
      logic [1:0] req_type;
      logic [7:0] rx_data;
   } req_item_type;

   typedef struct packed {
      logic [1:0] result_kind;
      logic [7:0] command_code;
      logic [7:0] height_value;
      logic       is_set_height;
      logic [7:0] payload_byte;
      logic       payload_last;
      logic [7:0] drop_count;
      logic       command_pending;
      logic [1:0] frames_queued;
   } rsp_item_type;

endpackage

FILE: rtl/dual_header_uart_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dual header UART deframer
// Splits received UART bytes into command frames and tuning frames.
// ----------------------------------------------------------------------------
// Usage: each req beat is a received byte, an overrun event, a read of the
// command slot or a pop of the tuning ring. Byte, overrun and read beats give
// one rsp beat in the cycle after acceptance. A pop of a queued frame gives one
// payload beat per body byte, the first once the stream counter, ring read and
// output stage have registered, then one per cycle unless rsp stalls, the last
// flagged payload_last; the ring store's one read port sets the streaming rate.
// Command frames go to a single holding slot; tuning frames go to a ring of
// RING_SLOTS slots, each MAX_PAYLOAD bytes, holding up to RING_SLOTS-1 frames.
// Body bytes are written straight into the free ring slot as they arrive.
// Status fields of every rsp beat show the state after its req beat.
// Reset clears the parser, the slot, the ring pointers and the drop counter;
// the ring store itself needs no clearing pass. A stalled rsp holds its beat;
// req_ready drops until the beat leaves, and a pop stream pauses with up to two
// bytes parked in the output and skid stages. The user must write registers
// through csr_we, csr_index and csr_wdata while idle, unchecked by the block.
// ----------------------------------------------------------------------------
module dual_header_uart_deframer
   import dhud_pkg::*;
#(
   parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF,
   parameter int RING_SLOTS  = RING_SLOTS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_item_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_item_type rsp_data,
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [7:0]   csr_wdata
);

   localparam int IDX_W  = $clog2(MAX_PAYLOAD);
   localparam int LEN_W  = $clog2(MAX_PAYLOAD + 1);
   localparam int SLOT_W = $clog2(RING_SLOTS);
   localparam int ADDR_W = SLOT_W + IDX_W;

   localparam logic [7:0]        MAX_LEN_B = 8'(MAX_PAYLOAD);
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(RING_SLOTS - 1);
   localparam logic [SLOT_W:0]   SLOTS_EXT = (SLOT_W + 1)'(RING_SLOTS);

   // Parser phases
   localparam logic [2:0] PH_HUNT  = 3'd0;
   localparam logic [2:0] PH_CMD   = 3'd1;
   localparam logic [2:0] PH_TLEN  = 3'd2;
   localparam logic [2:0] PH_TBODY = 3'd3;
   localparam logic [2:0] PH_TSUM  = 3'd4;

   // Configuration
   logic [7:0] cmd_head_ff, cmd_head_in;
   logic [7:0] tun_head_ff, tun_head_in;
   logic [7:0] set_code_ff, set_code_in;

   // Parser state
   logic [2:0]       phase_ff, phase_in;
   logic [LEN_W-1:0] byte_idx_ff, byte_idx_in;
   logic [LEN_W-1:0] frame_len_ff, frame_len_in;
   logic [7:0]       sum_ff, sum_in;
   logic [7:0]       cand_cmd_ff, cand_cmd_in;
   logic [7:0]       cand_hgt_ff, cand_hgt_in;

   // Command slot
   logic [7:0] held_cmd_ff, held_cmd_in;
   logic [7:0] held_hgt_ff, held_hgt_in;
   logic       slot_full_ff, slot_full_in;

   // Ring control
   logic [SLOT_W-1:0] wr_slot_ff, wr_slot_in;
   logic [SLOT_W-1:0] rd_slot_ff, rd_slot_in;
   logic [7:0]        lost_ff, lost_in;
   logic [LEN_W-1:0]  ring_len_ff [RING_SLOTS];
   logic              len_we;
   logic [SLOT_W-1:0] wr_slot_nxt, rd_slot_nxt;
   logic [SLOT_W:0]   queued;

   // Pop streaming
   logic [SLOT_W-1:0] strm_slot_ff, strm_slot_in;
   logic [IDX_W-1:0]  strm_idx_ff, strm_idx_in;
   logic [LEN_W-1:0]  strm_left_ff, strm_left_in;
   logic              rd_pend_ff, rd_pend_in;
   logic              rd_last_ff, rd_last_in;
   logic              skid_valid_ff, skid_valid_in;
   logic [7:0]        skid_data_ff, skid_data_in;
   logic              skid_last_ff, skid_last_in;

   // Output stage
   logic       out_valid_ff, out_valid_in;
   logic [1:0] out_kind_ff, out_kind_in;
   logic [7:0] out_cmd_ff, out_cmd_in;
   logic [7:0] out_hgt_ff, out_hgt_in;
   logic       out_set_ff, out_set_in;
   logic [7:0] out_pay_ff, out_pay_in;
   logic       out_last_ff, out_last_in;

   // Ring store ports
   logic              mem_we, mem_re;
   logic [ADDR_W-1:0] mem_waddr, mem_raddr;
   logic [7:0]        mem_rdata;

   logic       accept, take, out_free, busy, issue;
   logic       load;
   logic [1:0] load_kind;
   logic [7:0] load_cmd, load_hgt;
   logic       load_set;
   logic [1:0] occ;
   logic [7:0] rx;

   assign rx          = req_data.rx_data;
   assign take        = out_valid_ff & rsp_ready;
   assign out_free    = ~out_valid_ff | take;
   assign busy        = (strm_left_ff != '0) | rd_pend_ff | skid_valid_ff;
   assign req_ready   = ~busy & out_free;
   assign accept      = req_valid & req_ready;
   assign wr_slot_nxt = (wr_slot_ff == LAST_SLOT) ? '0 : wr_slot_ff + 1'b1;
   assign rd_slot_nxt = (rd_slot_ff == LAST_SLOT) ? '0 : rd_slot_ff + 1'b1;

   // Frames in the ring, wrapped around the slot count
   always_comb begin
      if (wr_slot_ff >= rd_slot_ff) begin
         queued = {1'b0, wr_slot_ff} - {1'b0, rd_slot_ff};
      end else begin
         queued = {1'b0, wr_slot_ff} + SLOTS_EXT - {1'b0, rd_slot_ff};
      end
   end

   // Configuration writes
   always_comb begin
      cmd_head_in = cmd_head_ff;
      tun_head_in = tun_head_ff;
      set_code_in = set_code_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_CMD_HEAD: cmd_head_in = csr_wdata;
            CSR_TUN_HEAD: tun_head_in = csr_wdata;
            CSR_SET_CODE: set_code_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // Parse bytes, handle overruns, serve reads and start pops
   always_comb begin
      phase_in     = phase_ff;
      byte_idx_in  = byte_idx_ff;
      frame_len_in = frame_len_ff;
      sum_in       = sum_ff;
      cand_cmd_in  = cand_cmd_ff;
      cand_hgt_in  = cand_hgt_ff;
      held_cmd_in  = held_cmd_ff;
      held_hgt_in  = held_hgt_ff;
      slot_full_in = slot_full_ff;
      wr_slot_in   = wr_slot_ff;
      rd_slot_in   = rd_slot_ff;
      lost_in      = lost_ff;
      len_we       = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = {wr_slot_ff, byte_idx_ff[IDX_W-1:0]};
      strm_slot_in = strm_slot_ff;
      load         = 1'b0;
      load_kind    = KIND_STATUS;
      load_cmd     = '0;
      load_hgt     = '0;
      load_set     = 1'b0;
      if (accept) begin
         unique case (req_data.req_type)
            REQ_BYTE: begin
               load = 1'b1;
               unique case (phase_ff)
                  PH_CMD: begin
                     byte_idx_in = byte_idx_ff + 1'b1;
                     sum_in      = sum_ff + rx;
                     if (byte_idx_ff == LEN_W'(1)) begin
                        cand_cmd_in = rx;
                     end else if (byte_idx_ff == LEN_W'(2)) begin
                        cand_hgt_in = rx;
                     end else begin
                        // Checksum byte closes the frame
                        if (rx == sum_ff && !slot_full_ff) begin
                           held_cmd_in  = cand_cmd_ff;
                           held_hgt_in  = cand_hgt_ff;
                           slot_full_in = 1'b1;
                        end
                        phase_in = PH_HUNT;
                     end
                  end
                  PH_TLEN: begin
                     if (rx == 8'd0 || rx > MAX_LEN_B) begin
                        phase_in = PH_HUNT;
                     end else begin
                        frame_len_in = rx[LEN_W-1:0];
                        sum_in       = sum_ff + rx;
                        byte_idx_in  = '0;
                        phase_in     = PH_TBODY;
                     end
                  end
                  PH_TBODY: begin
                     // Body bytes land directly in the free ring slot
                     mem_we      = 1'b1;
                     byte_idx_in = byte_idx_ff + 1'b1;
                     sum_in      = sum_ff + rx;
                     if (byte_idx_ff + 1'b1 >= frame_len_ff) begin
                        phase_in = PH_TSUM;
                     end
                  end
                  PH_TSUM: begin
                     if (rx == sum_ff) begin
                        if (wr_slot_nxt == rd_slot_ff) begin
                           if (lost_ff != LOST_MAX) begin
                              lost_in = lost_ff + 1'b1;
                           end
                        end else begin
                           len_we     = 1'b1;
                           wr_slot_in = wr_slot_nxt;
                        end
                     end
                     phase_in = PH_HUNT;
                  end
                  default: begin
                     phase_in = PH_HUNT;
                     if (rx == cmd_head_ff) begin
                        sum_in      = rx;
                        byte_idx_in = LEN_W'(1);
                        phase_in    = PH_CMD;
                     end else if (rx == tun_head_ff) begin
                        sum_in   = rx;
                        phase_in = PH_TLEN;
                     end
                  end
               endcase
            end
            REQ_OVERRUN: begin
               load     = 1'b1;
               phase_in = PH_HUNT;
            end
            REQ_READ: begin
               load = 1'b1;
               if (!slot_full_ff) begin
                  load_kind = KIND_EMPTY;
               end else begin
                  load_kind    = KIND_COMMAND;
                  load_cmd     = held_cmd_ff;
                  load_hgt     = held_hgt_ff;
                  load_set     = (held_cmd_ff == set_code_ff);
                  slot_full_in = 1'b0;
               end
            end
            default: begin
               if (rd_slot_ff == wr_slot_ff) begin
                  load      = 1'b1;
                  load_kind = KIND_EMPTY;
               end else begin
                  strm_slot_in = rd_slot_ff;
                  rd_slot_in   = rd_slot_nxt;
               end
            end
         endcase
      end
   end

   // Issue ring reads while output and skid have room
   always_comb begin
      occ = {1'b0, rd_pend_ff} + {1'b0, skid_valid_ff} + {1'b0, out_valid_ff & ~take};
      issue        = (strm_left_ff != '0) && (occ < 2'd2);
      mem_re       = issue;
      mem_raddr    = {strm_slot_ff, strm_idx_ff};
      strm_idx_in  = strm_idx_ff;
      strm_left_in = strm_left_ff;
      rd_pend_in   = issue;
      rd_last_in   = rd_last_ff;
      if (accept && req_data.req_type == REQ_POP && rd_slot_ff != wr_slot_ff) begin
         strm_idx_in  = '0;
         strm_left_in = ring_len_ff[rd_slot_ff];
      end else if (issue) begin
         strm_idx_in  = strm_idx_ff + 1'b1;
         strm_left_in = strm_left_ff - 1'b1;
         rd_last_in   = (strm_left_ff == LEN_W'(1));
      end
   end

   // Advance output and skid stages
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_kind_in   = out_kind_ff;
      out_cmd_in    = out_cmd_ff;
      out_hgt_in    = out_hgt_ff;
      out_set_in    = out_set_ff;
      out_pay_in    = out_pay_ff;
      out_last_in   = out_last_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      skid_last_in  = skid_last_ff;
      if (out_free) begin
         if (load) begin
            out_valid_in = 1'b1;
            out_kind_in  = load_kind;
            out_cmd_in   = load_cmd;
            out_hgt_in   = load_hgt;
            out_set_in   = load_set;
            out_pay_in   = '0;
            out_last_in  = 1'b1;
         end else if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_kind_in   = KIND_PAYLOAD;
            out_cmd_in    = '0;
            out_hgt_in    = '0;
            out_set_in    = 1'b0;
            out_pay_in    = skid_data_ff;
            out_last_in   = skid_last_ff;
            skid_valid_in = rd_pend_ff;
            skid_data_in  = mem_rdata;
            skid_last_in  = rd_last_ff;
         end else if (rd_pend_ff) begin
            out_valid_in = 1'b1;
            out_kind_in  = KIND_PAYLOAD;
            out_cmd_in   = '0;
            out_hgt_in   = '0;
            out_set_in   = 1'b0;
            out_pay_in   = mem_rdata;
            out_last_in  = rd_last_ff;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (rd_pend_ff) begin
         // Park the arriving byte behind the stalled beat
         skid_valid_in = 1'b1;
         skid_data_in  = mem_rdata;
         skid_last_in  = rd_last_ff;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_head_ff   <= CMD_HEAD_RST;
         tun_head_ff   <= TUN_HEAD_RST;
         set_code_ff   <= SET_CODE_RST;
         phase_ff      <= PH_HUNT;
         byte_idx_ff   <= '0;
         frame_len_ff  <= '0;
         sum_ff        <= '0;
         held_cmd_ff   <= '0;
         held_hgt_ff   <= '0;
         slot_full_ff  <= 1'b0;
         wr_slot_ff    <= '0;
         rd_slot_ff    <= '0;
         lost_ff       <= '0;
         strm_left_ff  <= '0;
         rd_pend_ff    <= 1'b0;
         skid_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         cmd_head_ff   <= cmd_head_in;
         tun_head_ff   <= tun_head_in;
         set_code_ff   <= set_code_in;
         phase_ff      <= phase_in;
         byte_idx_ff   <= byte_idx_in;
         frame_len_ff  <= frame_len_in;
         sum_ff        <= sum_in;
         held_cmd_ff   <= held_cmd_in;
         held_hgt_ff   <= held_hgt_in;
         slot_full_ff  <= slot_full_in;
         wr_slot_ff    <= wr_slot_in;
         rd_slot_ff    <= rd_slot_in;
         lost_ff       <= lost_in;
         strm_left_ff  <= strm_left_in;
         rd_pend_ff    <= rd_pend_in;
         skid_valid_ff <= skid_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cand_cmd_ff  <= cand_cmd_in;
      cand_hgt_ff  <= cand_hgt_in;
      strm_slot_ff <= strm_slot_in;
      strm_idx_ff  <= strm_idx_in;
      rd_last_ff   <= rd_last_in;
      skid_data_ff <= skid_data_in;
      skid_last_ff <= skid_last_in;
      out_kind_ff  <= out_kind_in;
      out_cmd_ff   <= out_cmd_in;
      out_hgt_ff   <= out_hgt_in;
      out_set_ff   <= out_set_in;
      out_pay_ff   <= out_pay_in;
      out_last_ff  <= out_last_in;
      if (len_we) begin
         ring_len_ff[wr_slot_ff] <= frame_len_ff;
      end
   end

   dhud_ring_ram #(
      .ADDR_W (ADDR_W)
   ) u_ring_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (rx),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   // Result beat: item fields from the output stage, status from live state
   assign rsp_valid = out_valid_ff;
   always_comb begin
      rsp_data.result_kind     = out_kind_ff;
      rsp_data.command_code    = out_cmd_ff;
      rsp_data.height_value    = out_hgt_ff;
      rsp_data.is_set_height   = out_set_ff;
      rsp_data.payload_byte    = out_pay_ff;
      rsp_data.payload_last    = out_last_ff;
      rsp_data.drop_count      = lost_ff;
      rsp_data.command_pending = slot_full_ff;
      rsp_data.frames_queued   = queued[1:0];
   end

endmodule

FILE: rtl/dhud_ring_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tuning ring byte store
// One write port and one read port, with registered read data.
// ----------------------------------------------------------------------------
module dhud_ring_ram #(
   parameter int ADDR_W = 7
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [7:0]        wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [7:0]        rd_data
);

   logic [7:0] mem [2**ADDR_W];
   logic [7:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/dhud_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dual header UART deframer port checker
// Watches the req and rsp channels of the top level and flags slips.
// ----------------------------------------------------------------------------
`include "dual_header_uart_deframer_macros.svh"

module dhud_checker
   import dhud_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_ready,
   input req_item_type req_data,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input rsp_item_type rsp_data
);

   // A stalled rsp beat holds back the next req beat
   `DHUD_ASSERT_NOW(a_stall_blocks_req, rsp_valid && !rsp_ready, !req_ready,
      "req accepted while a rsp beat is stalled")

   // Non-pop beats answer with a single final beat in the next cycle
   `DHUD_ASSERT_NEXT(a_single_answer,
      req_valid && req_ready && req_data.req_type != REQ_POP,
      rsp_valid && rsp_data.payload_last && rsp_data.result_kind != KIND_PAYLOAD,
      "single-beat request did not answer with a final beat")

   // Command fields stay clear outside command beats
   `DHUD_ASSERT_NOW(a_cmd_fields_clear,
      rsp_valid && rsp_data.result_kind != KIND_COMMAND,
      rsp_data.command_code == 8'd0 && rsp_data.height_value == 8'd0 &&
         !rsp_data.is_set_height,
      "command fields set on a non-command beat")

   // Hold a stalled rsp beat
   `DHUD_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_data), "stalled rsp beat changed")

endmodule

bind dual_header_uart_deframer dhud_checker u_dhud_checker (.*);

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dual header UART deframer testbench
// Feeds command frames, tuning frames, overruns, slot reads and ring pops
// through the req channel under random idling and back-pressure. A behavioural
// copy of the parser, the command slot and the tuning ring predicts every rsp
// beat, and each beat that leaves the block is compared field by field with
// the oldest prediction. Register settings change between traffic phases.
// ----------------------------------------------------------------------------
module tb_top
   import dhud_pkg::*;
();

   localparam int          MAXP             = MAX_PAYLOAD_DEF;
   localparam int          SLOTS            = RING_SLOTS_DEF;
   localparam int          CMD_FRAME_LEN    = 4;
   localparam int          IDLE_MAX         = 14;
   localparam int          LONG_HOLD_CYCLES = 300;
   localparam int          SETTLE_CYCLES    = 8;
   localparam int          OVERFLOW_FRAMES  = 6;
   localparam int unsigned CYCLE_LIMIT      = 1_000_000;

   typedef enum logic [2:0] {
      SEEK_HEAD,
      CMD_BODY,
      TUNE_LEN,
      TUNE_BODY,
      TUNE_SUM
   } parse_state_type;

   // One directed beat; the typed result replaces the prediction where set
   typedef struct packed {
      req_item_type beat;
      logic         typed;
      rsp_item_type rsp;
   } script_row_type;

   localparam rsp_item_type NO_RSP = '0;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_item_type req_data  = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_item_type rsp_data;
   logic         csr_we    = 1'b0;
   logic [1:0]   csr_index = CSR_CMD_HEAD;
   logic [7:0]   csr_wdata = '0;

   // Register copies
   logic [7:0]   head_cmd        = CMD_HEAD_RST;
   logic [7:0]   head_tune       = TUN_HEAD_RST;
   logic [7:0]   code_set_height = SET_CODE_RST;

   // Parser, command slot and tuning ring copies
   parse_state_type parse_state = SEEK_HEAD;
   int unsigned  frame_pos   = 0;
   int unsigned  tune_len    = 0;
   logic [7:0]   tune_sum    = '0;
   logic [7:0]   frame_buf [MAXP];
   logic [7:0]   slot_cmd    = '0;
   logic [7:0]   slot_hgt    = '0;
   logic         slot_held   = 1'b0;
   logic [7:0]   ring_mem [SLOTS][MAXP];
   int unsigned  ring_len [SLOTS];
   int unsigned  ring_wr     = 0;
   int unsigned  ring_rd     = 0;
   logic [7:0]   lost_count  = '0;

   rsp_item_type beat_results [$];
   rsp_item_type expected_rsp [$];

   int unsigned  items_sent       = 0;
   int unsigned  mismatches       = 0;
   int unsigned  cycle_count      = 0;
   bit           steady_tx        = 1'b0;
   bit           steady_rx        = 1'b0;
   bit           rsp_hold_request = 1'b0;

   // Directed opening: empty reads, extremes, slot full, bad length and sum,
   // overrun inside a frame, then a pop of the single good tuning frame
   script_row_type script [26] = '{
      {REQ_READ,    8'h00, 1'b1, KIND_EMPTY,   8'h00, 8'h00, 1'b0, 8'h00, 1'b1, 8'h00, 1'b0, 2'd0},
      {REQ_POP,     8'hFF, 1'b1, KIND_EMPTY,   8'h00, 8'h00, 1'b0, 8'h00, 1'b1, 8'h00, 1'b0, 2'd0},
      {REQ_OVERRUN, 8'h00, 1'b1, KIND_STATUS,  8'h00, 8'h00, 1'b0, 8'h00, 1'b1, 8'h00, 1'b0, 2'd0},
      {REQ_BYTE,    8'h00, 1'b1, KIND_STATUS,  8'h00, 8'h00, 1'b0, 8'h00, 1'b1, 8'h00, 1'b0, 2'd0},
      {REQ_BYTE,    8'hAA, 1'b0, NO_RSP},
      {REQ_BYTE,    8'h01, 1'b0, NO_RSP},
      {REQ_BYTE,    8'hFF, 1'b0, NO_RSP},
      {REQ_BYTE,    8'hAA, 1'b0, NO_RSP},
      {REQ_BYTE,    8'hAA, 1'b0, NO_RSP},
      {REQ_BYTE,    8'h02, 1'b0, NO_RSP},
      {REQ_BYTE,    8'h03, 1'b0, NO_RSP},
      {REQ_BYTE,    8'hAF, 1'b0, NO_RSP},
      {REQ_READ,    8'h00, 1'b1, KIND_COMMAND, 8'h01, 8'hFF, 1'b1, 8'h00, 1'b1, 8'h00, 1'b0, 2'd0},
      {REQ_BYTE,    8'hA5, 1'b0, NO_RSP},
      {REQ_BYTE,    8'h01, 1'b0, NO_RSP},
      {REQ_BYTE,    8'hFF, 1'b0, NO_RSP},
      {REQ_BYTE,    8'hA5, 1'b0, NO_RSP},
      {REQ_BYTE,    8'hA5, 1'b0, NO_RSP},
      {REQ_BYTE,    8'h00, 1'b0, NO_RSP},
      {REQ_BYTE,    8'hA5, 1'b0, NO_RSP},
      {REQ_BYTE,    8'h01, 1'b0, NO_RSP},
      {REQ_BYTE,    8'h00, 1'b0, NO_RSP},
      {REQ_BYTE,    8'h00, 1'b0, NO_RSP},
      {REQ_BYTE,    8'hAA, 1'b0, NO_RSP},
      {REQ_OVERRUN, 8'hFF, 1'b0, NO_RSP},
      {REQ_POP,     8'h00, 1'b1, KIND_PAYLOAD, 8'h00, 8'h00, 1'b0, 8'hFF, 1'b1, 8'h00, 1'b0, 2'd0}
   };

   dual_header_uart_deframer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #10 clock = ~clock;

   // Abandon a run that hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL dual_header_uart_deframer");
         $finish;
      end
   end

   // Build one rsp beat; status fields reflect the state after the req beat
   function automatic rsp_item_type beat_out(logic [1:0] kind, logic [7:0] cmd,
                                             logic [7:0] hgt, logic set,
                                             logic [7:0] pay, logic last);
      rsp_item_type r;
      r.result_kind     = kind;
      r.command_code    = cmd;
      r.height_value    = hgt;
      r.is_set_height   = set;
      r.payload_byte    = pay;
      r.payload_last    = last;
      r.drop_count      = lost_count;
      r.command_pending = slot_held;
      r.frames_queued   = 2'((ring_wr + SLOTS - ring_rd) % SLOTS);
      return r;
   endfunction

   // Advance the deframer copy by one req beat and collect its rsp beats
   function automatic void deframe_beat(req_item_type beat);
      logic [7:0]  b;
      logic [7:0]  total;
      int unsigned slot;
      int unsigned n;
      int unsigned i;
      b = beat.rx_data;
      beat_results.delete();
      case (beat.req_type)
         REQ_BYTE: begin
            case (parse_state)
               CMD_BODY: begin
                  if (frame_pos < CMD_FRAME_LEN) frame_buf[frame_pos] = b;
                  frame_pos++;
                  if (frame_pos >= CMD_FRAME_LEN) begin
                     total = frame_buf[0] + frame_buf[1] + frame_buf[2];
                     // Keep a good frame only while the slot is empty
                     if (total == frame_buf[3] && !slot_held) begin
                        slot_cmd  = frame_buf[1];
                        slot_hgt  = frame_buf[2];
                        slot_held = 1'b1;
                     end
                     parse_state = SEEK_HEAD;
                  end
               end
               TUNE_LEN: begin
                  if (b == 0 || b > MAXP) begin
                     parse_state = SEEK_HEAD;
                  end else begin
                     tune_len    = b;
                     tune_sum    = tune_sum + b;
                     frame_pos   = 0;
                     parse_state = TUNE_BODY;
                  end
               end
               TUNE_BODY: begin
                  if (frame_pos < MAXP) frame_buf[frame_pos] = b;
                  frame_pos++;
                  tune_sum = tune_sum + b;
                  if (frame_pos >= tune_len) parse_state = TUNE_SUM;
               end
               TUNE_SUM: begin
                  if (b == tune_sum) begin
                     // Count a drop when the ring is full, saturating
                     if ((ring_wr + 1) % SLOTS == ring_rd) begin
                        if (lost_count != LOST_MAX) lost_count++;
                     end else begin
                        for (i = 0; i < tune_len; i++) ring_mem[ring_wr][i] = frame_buf[i];
                        ring_len[ring_wr] = tune_len;
                        ring_wr = (ring_wr + 1) % SLOTS;
                     end
                  end
                  parse_state = SEEK_HEAD;
               end
               default: begin
                  // Hunt for a head; the command head wins a tie
                  parse_state = SEEK_HEAD;
                  if (b == head_cmd) begin
                     frame_buf[0] = b;
                     frame_pos    = 1;
                     parse_state  = CMD_BODY;
                  end else if (b == head_tune) begin
                     tune_sum    = b;
                     parse_state = TUNE_LEN;
                  end
               end
            endcase
            beat_results.push_back(beat_out(KIND_STATUS, '0, '0, 1'b0, '0, 1'b1));
         end
         REQ_OVERRUN: begin
            parse_state = SEEK_HEAD;
            beat_results.push_back(beat_out(KIND_STATUS, '0, '0, 1'b0, '0, 1'b1));
         end
         REQ_READ: begin
            if (!slot_held) begin
               beat_results.push_back(beat_out(KIND_EMPTY, '0, '0, 1'b0, '0, 1'b1));
            end else begin
               slot_held = 1'b0;
               beat_results.push_back(beat_out(KIND_COMMAND, slot_cmd, slot_hgt,
                                               slot_cmd == code_set_height, '0, 1'b1));
            end
         end
         default: begin
            if (ring_rd == ring_wr) begin
               beat_results.push_back(beat_out(KIND_EMPTY, '0, '0, 1'b0, '0, 1'b1));
            end else begin
               slot = ring_rd;
               n    = (ring_len[slot] > MAXP) ? MAXP : ring_len[slot];
               ring_rd = (ring_rd + 1) % SLOTS;
               if (n == 0) begin
                  beat_results.push_back(beat_out(KIND_EMPTY, '0, '0, 1'b0, '0, 1'b1));
               end else begin
                  for (i = 0; i < n; i++)
                     beat_results.push_back(beat_out(KIND_PAYLOAD, '0, '0, 1'b0,
                                                     ring_mem[slot][i], i == n - 1));
               end
            end
         end
      endcase
   endfunction

   // Offer one req beat after a random idle gap, hold it until accepted
   task automatic offer_beat(input logic [1:0] kind, input logic [7:0] data,
                             input logic typed = 1'b0, input rsp_item_type typed_rsp = '0);
      int unsigned gap;
      req_item_type beat;
      beat = {kind, data};
      gap  = steady_tx ? 0 : $urandom_range(0, IDLE_MAX);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      deframe_beat(beat);
      if (typed) expected_rsp.push_back(typed_rsp);
      else foreach (beat_results[k]) expected_rsp.push_back(beat_results[k]);
   endtask

   // Tuning frame of the given length; bad lengths stop after the length byte
   task automatic send_tuning_frame(input int unsigned len, input bit spoil);
      logic [7:0] frame_sum;
      logic [7:0] body;
      offer_beat(REQ_BYTE, head_tune);
      offer_beat(REQ_BYTE, 8'(len));
      if (len == 0 || len > MAXP) return;
      frame_sum = head_tune + 8'(len);
      repeat (len) begin
         body      = 8'($urandom);
         frame_sum = frame_sum + body;
         offer_beat(REQ_BYTE, body);
      end
      if (spoil) frame_sum = frame_sum ^ 8'($urandom_range(1, 255));
      offer_beat(REQ_BYTE, frame_sum);
   endtask

   // Mostly well-formed frames with random content, plus reads, pops and noise
   task automatic run_random(input int unsigned count);
      int unsigned stop_at;
      int unsigned pick;
      int unsigned len;
      logic [7:0]  code;
      logic [7:0]  height;
      logic [7:0]  frame_sum;
      stop_at = items_sent + count;
      while (items_sent < stop_at) begin
         if ($urandom_range(0, 39) == 0) begin
            steady_tx = ($urandom_range(0, 3) == 0);
            steady_rx = ($urandom_range(0, 3) == 0);
         end
         pick = $urandom_range(0, 99);
         if (pick < 30) begin
            code      = ($urandom_range(0, 3) == 0) ? code_set_height : 8'($urandom);
            height    = 8'($urandom);
            frame_sum = head_cmd + code + height;
            if ($urandom_range(0, 7) == 0) frame_sum = frame_sum ^ 8'($urandom_range(1, 255));
            offer_beat(REQ_BYTE, head_cmd);
            offer_beat(REQ_BYTE, code);
            offer_beat(REQ_BYTE, height);
            offer_beat(REQ_BYTE, frame_sum);
         end else if (pick < 55) begin
            case ($urandom_range(0, 15))
               0, 1: len = MAXP;
               2: len = $urandom_range(0, 1) ? 0 : $urandom_range(MAXP + 1, 255);
               default: len = $urandom_range(1, 6);
            endcase
            send_tuning_frame(len, $urandom_range(0, 7) == 0);
         end else if (pick < 70) begin
            offer_beat(REQ_READ, 8'($urandom));
         end else if (pick < 85) begin
            offer_beat(REQ_POP, 8'($urandom));
         end else if (pick < 90) begin
            offer_beat(REQ_OVERRUN, 8'($urandom));
         end else if (pick < 95) begin
            offer_beat(REQ_BYTE, 8'($urandom));
         end else begin
            // Broken frame: a head and a few stray bytes
            offer_beat(REQ_BYTE, $urandom_range(0, 1) ? head_cmd : head_tune);
            repeat ($urandom_range(1, 3)) offer_beat(REQ_BYTE, 8'($urandom));
         end
      end
   endtask

   // Drop valid and wait for every outstanding rsp beat, then a short tail
   task automatic settle();
      req_valid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write all three registers on consecutive edges while idle
   task automatic program_registers(input logic [7:0] cmd_head, input logic [7:0] tune_head,
                                    input logic [7:0] set_code);
      csr_we    <= 1'b1;
      csr_index <= CSR_CMD_HEAD;
      csr_wdata <= cmd_head;
      @(posedge clock);
      csr_index <= CSR_TUN_HEAD;
      csr_wdata <= tune_head;
      @(posedge clock);
      csr_index <= CSR_SET_CODE;
      csr_wdata <= set_code;
      @(posedge clock);
      csr_we          <= 1'b0;
      head_cmd        = cmd_head;
      head_tune       = tune_head;
      code_set_height = set_code;
   endtask

   task automatic flag_mismatch(input string what, input int unsigned want,
                                input int unsigned got);
      mismatches++;
      if (mismatches <= 40)
         $display("mismatch at cycle %0d: %s expected %0d got %0d",
                  cycle_count, what, want, got);
   endtask

   // Compare each accepted rsp beat with the oldest prediction
   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsp.size() == 0) begin
            flag_mismatch("rsp beat with nothing outstanding, kind", 0, rsp_data.result_kind);
         end else begin
            want = expected_rsp.pop_front();
            if (rsp_data.result_kind !== want.result_kind)
               flag_mismatch("result_kind", want.result_kind, rsp_data.result_kind);
            if (rsp_data.command_code !== want.command_code)
               flag_mismatch("command_code", want.command_code, rsp_data.command_code);
            if (rsp_data.height_value !== want.height_value)
               flag_mismatch("height_value", want.height_value, rsp_data.height_value);
            if (rsp_data.is_set_height !== want.is_set_height)
               flag_mismatch("is_set_height", want.is_set_height, rsp_data.is_set_height);
            if (rsp_data.payload_byte !== want.payload_byte)
               flag_mismatch("payload_byte", want.payload_byte, rsp_data.payload_byte);
            if (rsp_data.payload_last !== want.payload_last)
               flag_mismatch("payload_last", want.payload_last, rsp_data.payload_last);
            if (rsp_data.drop_count !== want.drop_count)
               flag_mismatch("drop_count", want.drop_count, rsp_data.drop_count);
            if (rsp_data.command_pending !== want.command_pending)
               flag_mismatch("command_pending", want.command_pending, rsp_data.command_pending);
            if (rsp_data.frames_queued !== want.frames_queued)
               flag_mismatch("frames_queued", want.frames_queued, rsp_data.frames_queued);
         end
      end
   end

   // Receiver: random stall before each beat, one long hold-off on request
   initial begin
      int unsigned stall;
      wait (!reset);
      forever begin
         if (rsp_hold_request) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            rsp_hold_request = 1'b0;
         end else begin
            stall = steady_rx ? 0 : $urandom_range(0, IDLE_MAX);
            if (stall != 0) begin
               rsp_ready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // Sender: directed table, then random phases under several register settings
   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (script[r])
         offer_beat(script[r].beat.req_type, script[r].beat.rx_data,
                    script[r].typed, script[r].rsp);

      // Hold off the receiver while traffic keeps coming, so the block backs up
      rsp_hold_request = 1'b1;
      run_random(80);
      settle();

      // Extreme register values
      program_registers(8'h00, 8'hFF, 8'hFF);
      run_random(80);
      settle();

      // Equal heads: every frame parses as a command frame
      program_registers(8'h5A, 8'h5A, 8'h00);
      run_random(70);
      settle();

      // Fill the ring with longest frames, then overflow it with short frames
      program_registers(CMD_HEAD_RST, TUN_HEAD_RST, SET_CODE_RST);
      steady_tx = 1'b1;
      steady_rx = 1'b1;
      repeat (SLOTS - 1) send_tuning_frame(MAXP, 1'b0);
      repeat (OVERFLOW_FRAMES) send_tuning_frame(1, 1'b0);
      steady_tx = 1'b0;
      steady_rx = 1'b0;
      run_random(50);
      settle();

      if (mismatches == 0) begin
         $display("PASS dual_header_uart_deframer");
      end else begin
         $display("FAIL dual_header_uart_deframer");
      end
      $finish;
   end

endmodule

FILE: files.f
+incdir+rtl
rtl/dhud_pkg.sv
rtl/dhud_ring_ram.sv
rtl/dual_header_uart_deframer.sv
rtl/dhud_checker.sv
tb/tb_top.sv
